>>> design/crx_pkg.sv
// Shared types, constants and helpers for the CANopen receive node table decoder.
// No dependencies; every other design file but crx_ram refers to this package by scoped names.
package crx_pkg;

   localparam int NODE_COUNT  = 3;
   localparam int QUEUE_DEPTH = 2;

   // Identifier bits 10..7 select the frame class (0x580 and 0x180 shifted down).
   localparam logic [3:0] CLS_SDO_RSP = 4'hB;
   localparam logic [3:0] CLS_TPDO1   = 4'h3;

   localparam logic [15:0] OBJ_POSITION = 16'h6064;
   localparam logic [15:0] OBJ_STATUS   = 16'h6041;
   localparam logic [15:0] OBJ_CURRENT  = 16'h2027;
   localparam logic [15:0] OBJ_VELOCITY = 16'h606C;
   localparam logic [15:0] OBJ_DEMAND   = 16'h2031;
   localparam logic [15:0] OBJ_MODE     = 16'h6061;
   localparam logic [15:0] OBJ_ANALOG   = 16'h207C;
   localparam logic [7:0]  SUB_MAIN     = 8'h00;
   localparam logic [7:0]  SUB_ANALOG1  = 8'h01;

   localparam logic [6:0] SW_MASK         = 7'h6F;
   localparam logic [6:0] SW_FAULT        = 7'h08;
   localparam logic [6:0] SW_READY        = 7'h21;
   localparam logic [6:0] SW_SWITCHED_ON  = 7'h23;
   localparam logic [6:0] SW_DISABLED     = 7'h40;
   localparam logic [6:0] SW_OP_ENABLED   = 7'h27;

   typedef enum logic [1:0] {
      KIND_IGNORED = 2'd0,
      KIND_SDO     = 2'd1,
      KIND_TPDO    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ACT_NONE        = 3'd0,
      ACT_FAULT_RESET = 3'd1,
      ACT_ENABLE_VOLT = 3'd2,
      ACT_ENABLE_OP   = 3'd3,
      ACT_SHUTDOWN    = 3'd4,
      ACT_KEEP        = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_POSITION,
      OP_STATUS,
      OP_CURRENT,
      OP_VELOCITY,
      OP_DEMAND,
      OP_MODE,
      OP_ANALOG,
      OP_TPDO
   } op_type;

   typedef struct packed {
      logic [10:0] frame_id;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  byte4;
      logic [7:0]  byte5;
      logic [7:0]  byte6;
      logic [7:0]  byte7;
   } req_type;

   typedef struct packed {
      logic [1:0]         frame_kind;
      logic [6:0]         node_number;
      logic [15:0]        status_word;
      logic signed [31:0] position;
      logic signed [15:0] motor_current;
      logic signed [31:0] velocity;
      logic signed [31:0] current_demand;
      logic signed [7:0]  mode_display;
      logic signed [15:0] analog_in;
      logic [2:0]         drive_action;
   } rsp_type;

   // Classified frame handed from the front end to the back end.
   typedef struct packed {
      kind_type    kind;
      logic [6:0]  node_number;
      op_type      op;
      logic [31:0] value;
   } cmd_type;

   // One node record as held in the table memory.
   typedef struct packed {
      logic [15:0] status_word;
      logic [31:0] position;
      logic [15:0] motor_current;
      logic [31:0] velocity;
      logic [31:0] current_demand;
      logic [7:0]  mode_display;
      logic [15:0] analog_in;
   } rec_type;

   function automatic action_type action_for(input logic [15:0] sw);
      logic [6:0] masked;
      action_type act;
      masked = sw[6:0] & SW_MASK;
      unique case (masked)
         SW_FAULT:       act = ACT_FAULT_RESET;
         SW_READY:       act = ACT_ENABLE_VOLT;
         SW_SWITCHED_ON: act = ACT_ENABLE_OP;
         SW_DISABLED:    act = ACT_SHUTDOWN;
         SW_OP_ENABLED:  act = ACT_KEEP;
         default:        act = ACT_NONE;
      endcase
      return act;
   endfunction

endpackage

>>> design/canopen_rx_node_table_decoder_core.sv
// Top level of the CANopen receive decoder with its per-node record table.
// Depends on crx_pkg, crx_front, crx_cmd_queue, crx_back (and crx_ram below it).
//
// Usage:
//  - Input side is a queue: present a frame on req_data and raise push; the
//    beat is taken on a rising edge with push high and full low.
//  - Result side is a queue: while empty is low, rsp_data holds the oldest
//    result; raise pop to take that beat. Every frame gives exactly one result,
//    ignored frames included (kind 0, record fields and action zero).
//  - Path: a frame taken into an idle block is classified straight into the
//    command queue; the back end then reads the record from the table
//    (ST_IDLE), and merges, writes it back and registers the result (ST_MERGE).
//  - The back end reads a record and writes it back before it takes the
//    next frame (no forwarding path), and takes none while an unpopped result waits.
//  - A two-entry command queue between front and back keeps taking frames
//    while a result waits; full rises once it fills, behind a stalled result
//    or when frames arrive faster than the back end takes them.
//  - Reset (synchronous, active high) empties the queues and clears every
//    record's valid bit, so all node records read as zero right after reset;
//    no clearing pass is needed.
module canopen_rx_node_table_decoder_core #(
   parameter int NODE_COUNT = crx_pkg::NODE_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  crx_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output crx_pkg::rsp_type rsp_data
);

   crx_pkg::cmd_type front_cmd;
   crx_pkg::cmd_type q_data;
   logic             q_empty;
   logic             q_pop;

   // frame classification: node range, class, known SDO object
   crx_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .frame (req_data),
      .cmd   (front_cmd)
   );

   // decoupling queue; its full flag is the block's full
   crx_cmd_queue #(
      .DEPTH (crx_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .full      (full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   // table update and result register
   crx_back #(
      .NODE_COUNT (NODE_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

endmodule

>>> design/crx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module crx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/crx_front.sv
// Front end: classifies a received frame by identifier class, node and SDO object.
// Depends on crx_pkg.
module crx_front #(
   parameter int NODE_COUNT = crx_pkg::NODE_COUNT
) (
   input  crx_pkg::req_type frame,
   output crx_pkg::cmd_type cmd
);

   logic [6:0]  node;
   logic [3:0]  cls;
   logic        node_ok;
   logic [15:0] obj_index;
   logic [7:0]  obj_sub;

   always_comb begin
      node      = frame.frame_id[6:0];
      cls       = frame.frame_id[10:7];
      node_ok   = (node != 7'd0) && (node <= 7'(NODE_COUNT));
      obj_index = {frame.byte2, frame.byte1};
      obj_sub   = frame.byte3;

      cmd.node_number = node;
      cmd.value       = {frame.byte7, frame.byte6, frame.byte5, frame.byte4};
      cmd.kind        = crx_pkg::KIND_IGNORED;
      cmd.op          = crx_pkg::OP_NONE;

      if (node_ok && cls == crx_pkg::CLS_SDO_RSP) begin
         cmd.kind = crx_pkg::KIND_SDO;
         // known objects are disjoint, an unknown one leaves the record alone
         priority if (obj_index == crx_pkg::OBJ_POSITION && obj_sub == crx_pkg::SUB_MAIN)
            cmd.op = crx_pkg::OP_POSITION;
         else if (obj_index == crx_pkg::OBJ_STATUS && obj_sub == crx_pkg::SUB_MAIN)
            cmd.op = crx_pkg::OP_STATUS;
         else if (obj_index == crx_pkg::OBJ_CURRENT && obj_sub == crx_pkg::SUB_MAIN)
            cmd.op = crx_pkg::OP_CURRENT;
         else if (obj_index == crx_pkg::OBJ_VELOCITY && obj_sub == crx_pkg::SUB_MAIN)
            cmd.op = crx_pkg::OP_VELOCITY;
         else if (obj_index == crx_pkg::OBJ_DEMAND && obj_sub == crx_pkg::SUB_MAIN)
            cmd.op = crx_pkg::OP_DEMAND;
         else if (obj_index == crx_pkg::OBJ_MODE && obj_sub == crx_pkg::SUB_MAIN)
            cmd.op = crx_pkg::OP_MODE;
         else if (obj_index == crx_pkg::OBJ_ANALOG && obj_sub == crx_pkg::SUB_ANALOG1)
            cmd.op = crx_pkg::OP_ANALOG;
         else
            cmd.op = crx_pkg::OP_NONE;
      end else if (node_ok && cls == crx_pkg::CLS_TPDO1) begin
         cmd.kind = crx_pkg::KIND_TPDO;
         cmd.op   = crx_pkg::OP_TPDO;
      end
   end

endmodule

>>> design/crx_cmd_queue.sv
// Short FIFO of classified frames between the front end and the back end.
// Depends on crx_pkg.
module crx_cmd_queue #(
   parameter int DEPTH = crx_pkg::QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  crx_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output crx_pkg::cmd_type pop_data,
   output logic             empty
);

   crx_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

>>> design/crx_back.sv
// Back end: read-modify-write of the node record table and the result register.
// Depends on crx_pkg and crx_ram.
module crx_back #(
   parameter int NODE_COUNT = crx_pkg::NODE_COUNT,
   localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  crx_pkg::cmd_type q_data,
   output logic             q_pop,
   output crx_pkg::rsp_type rsp_data,
   output logic             empty,
   input  logic             pop
);

   localparam int REC_W = $bits(crx_pkg::rec_type);

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type             state_ff;
   crx_pkg::cmd_type      cmd_ff;
   crx_pkg::rsp_type      rsp_ff;
   logic                  out_valid_ff;
   logic [NODE_COUNT-1:0] valid_ff;

   logic                  slot_free;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [REC_W-1:0]      rd_data;
   logic [IDX_W-1:0]      cur_idx;
   logic                  live;
   crx_pkg::rec_type      old_rec;
   crx_pkg::rec_type      new_rec;
   logic                  wr_en;
   crx_pkg::rsp_type      result;

   always_comb begin
      slot_free = !out_valid_ff || pop;
      q_pop     = (state_ff == ST_IDLE) && !q_empty && slot_free;
      rd_en     = q_pop && (q_data.kind != crx_pkg::KIND_IGNORED);
      rd_addr   = IDX_W'(q_data.node_number - 7'd1);

      cur_idx   = IDX_W'(cmd_ff.node_number - 7'd1);
      live      = (cmd_ff.kind != crx_pkg::KIND_IGNORED);
      // an entry never written since reset reads as zero
      old_rec   = (live && valid_ff[cur_idx]) ? crx_pkg::rec_type'(rd_data) : '0;

      new_rec = old_rec;
      unique case (cmd_ff.op)
         crx_pkg::OP_POSITION: new_rec.position       = cmd_ff.value;
         crx_pkg::OP_STATUS:   new_rec.status_word    = cmd_ff.value[15:0];
         crx_pkg::OP_CURRENT:  new_rec.motor_current  = cmd_ff.value[15:0];
         crx_pkg::OP_VELOCITY: new_rec.velocity       = cmd_ff.value;
         crx_pkg::OP_DEMAND:   new_rec.current_demand = cmd_ff.value;
         crx_pkg::OP_MODE:     new_rec.mode_display   = cmd_ff.value[7:0];
         crx_pkg::OP_ANALOG:   new_rec.analog_in      = cmd_ff.value[15:0];
         crx_pkg::OP_TPDO: begin
            new_rec.motor_current = cmd_ff.value[15:0];
            new_rec.status_word   = cmd_ff.value[31:16];
         end
         default: new_rec = old_rec;
      endcase

      wr_en = (state_ff == ST_MERGE) && live;

      result.frame_kind     = cmd_ff.kind;
      result.node_number    = cmd_ff.node_number;
      result.status_word    = new_rec.status_word;
      result.position       = new_rec.position;
      result.motor_current  = new_rec.motor_current;
      result.velocity       = new_rec.velocity;
      result.current_demand = new_rec.current_demand;
      result.mode_display   = new_rec.mode_display;
      result.analog_in      = new_rec.analog_in;
      result.drive_action   = live ? crx_pkg::action_for(new_rec.status_word)
                                   : crx_pkg::ACT_NONE;
   end

   crx_ram #(
      .WIDTH (REC_W),
      .DEPTH (NODE_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_idx),
      .wr_data (REC_W'(new_rec)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         if (out_valid_ff && pop) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  cmd_ff   <= q_data;
                  state_ff <= ST_MERGE;
               end
            end
            ST_MERGE: begin
               rsp_ff       <= result;
               out_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
               if (wr_en) begin
                  valid_ff[cur_idx] <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_data = rsp_ff;
   assign empty    = !out_valid_ff;

endmodule
